### rtl/core/srd_pkg.sv
// ----------------------------------------------------------------------------
// Segmented RLE record decoder package
// Shared constants, codes, the decode phase type and the queue item layout.
// ----------------------------------------------------------------------------
`default_nettype none

package srd_pkg;

  // Default parameter values.
  localparam int DESCRIPTOR_BYTES_DEF = 14;
  localparam int COUNT_BITS_DEF       = 32;
  localparam int QUEUE_DEPTH_DEF      = 4;

  // Fixed stream layout.
  localparam int SRC_BITS     = 33;
  localparam int FIELD_BYTES  = 4;
  localparam int MIN_SOURCE   = 8;
  localparam int RUN_FLAG_BIT = 7;

  // A run control byte c repeats its value c - 125 times.
  localparam logic [7:0] RUN_BIAS = 8'd125;

  localparam logic [SRC_BITS-1:0] SRC_MAX = {SRC_BITS{1'b1}};

  // Result kinds; the stream outcome uses the same codes.
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;
  localparam logic [1:0] OC_NONE   = 2'd0;

  // Decode phase of the front end.
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SIZE,
    PH_DESC,
    PH_CONTROL,
    PH_RUNVAL,
    PH_LITERAL,
    PH_PAD
  } phase_t;

  // One queue item: an optional decoded pair, then an optional outcome.
  typedef struct packed {
    logic                pair_v;
    logic [7:0]          value;
    logic [7:0]          rep;
    logic                fin_v;
    logic [1:0]          kind;
    logic [31:0]         dec;
    logic [31:0]         recs;
    logic [SRC_BITS-1:0] pos;
  } entry_t;

endpackage

`default_nettype wire

### rtl/core/srd_if.sv
// ----------------------------------------------------------------------------
// Segmented RLE record decoder channels
// Valid/ready interfaces for the source byte stream and the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

interface srd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       is_last;

  modport source (output valid, src_byte, is_last, input ready);
  modport sink (input valid, src_byte, is_last, output ready);
endinterface

interface srd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  value;
  logic [7:0]  repeat_res;
  logic [31:0] decoded_total;
  logic [31:0] records_done;
  logic [32:0] source_position;
  logic        is_final;

  modport source (output valid, kind, value, repeat_res, decoded_total, records_done,
                  source_position, is_final, input ready);
  modport sink (input valid, kind, value, repeat_res, decoded_total, records_done,
                source_position, is_final, output ready);
endinterface

`default_nettype wire

### rtl/core/segmented_rle_record_decoder.sv
// ----------------------------------------------------------------------------
// Segmented RLE record decoder
// Decodes a packed stream of run-length coded records into value/repeat pairs
// and reports the stream outcome with its progress counts.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one source byte per item, with is_last on the final byte.
//   out_ch carries results: kind 0 items are decoded value/repeat pairs, and
//   the last source byte yields one outcome item (is_final = 1, kind 1 for
//   success, 2 for failure) with decoded_total, records_done and
//   source_position. A byte causes at most one pair and, if last, the outcome.
//   cfg_we/cfg_wdata write stop_after_first; write it only while idle.
// Timing:
//   The parser takes one byte per cycle while the queue is not full. A result
//   is written into the queue (QUEUE_DEPTH entries, four by default) when its
//   byte is accepted, then passes into the output register that offers it.
//   A last byte that also carries a pair gives the pair first, then the
//   outcome.
// Reset and stall:
//   Reset empties the queue, returns the parser to the header phase and clears
//   stop_after_first. While the receiver stalls, bytes keep being accepted
//   until the queue is full; then in_ch.ready drops until an item drains.
// ----------------------------------------------------------------------------
`default_nettype none

module segmented_rle_record_decoder import srd_pkg::*; #(
  parameter int DESCRIPTOR_BYTES = DESCRIPTOR_BYTES_DEF,
  parameter int COUNT_BITS       = COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  srd_in_if.sink    in_ch,
  srd_out_if.source out_ch
);

  logic   q_push, q_full, q_valid, q_pop;
  entry_t q_push_data, q_data;

  srd_front #(
    .DESCRIPTOR_BYTES(DESCRIPTOR_BYTES),
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(q_push_data)
  );

  srd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_data(q_push_data),
    .pop(q_pop),
    .full(q_full),
    .q_valid(q_valid),
    .q_data(q_data)
  );

  srd_back u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_data(q_data),
    .pop(q_pop),
    .out_ch(out_ch)
  );

  // The front end never pushes into a full queue.
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("item pushed into a full queue");

  // Every queue item carries a pair or an outcome.
  assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_push_data.pair_v || q_push_data.fin_v))
    else $error("empty item pushed into the queue");

  // An outcome is never a data kind, and a pair always has a repeat count.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.is_final ? (out_ch.kind != KIND_DATA)
                                      : ((out_ch.kind == KIND_DATA) &&
                                         (out_ch.repeat_res != 8'd0))))
    else $error("result kind does not match its role");

  // A result that is not taken stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable(out_ch.kind) && $stable(out_ch.value) &&
       $stable(out_ch.repeat_res) && $stable(out_ch.decoded_total) &&
       $stable(out_ch.records_done) && $stable(out_ch.source_position) &&
       $stable(out_ch.is_final)))
    else $error("result changed while stalled");

endmodule

`default_nettype wire

### rtl/core/srd_front.sv
// ----------------------------------------------------------------------------
// Segmented RLE record decoder front end
// Accepts one source byte per cycle unless the queue is full, runs the record
// parser and queues the decoded pair and the stream outcome that it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_front import srd_pkg::*; #(
  parameter int DESCRIPTOR_BYTES = DESCRIPTOR_BYTES_DEF,
  parameter int COUNT_BITS       = COUNT_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  srd_in_if.sink    in_ch,
  input  wire logic q_full,
  output logic      q_push,
  output entry_t    q_data
);

  localparam int SUM_W = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;
  localparam logic [3:0] DESC_LAST = 4'(DESCRIPTOR_BYTES);
  localparam logic [3:0] FIELD_LAST = 4'(FIELD_BYTES);

  // Parser state.
  phase_t                phase, phase_next, ph_mid;
  logic [3:0]            fbc, fbc_mid, fbc_next;
  logic [31:0]           word, word_mid, word_next;
  logic [SRC_BITS-1:0]   src_cnt, src_cnt_next;
  logic [COUNT_BITS-1:0] out_cnt, out_mid, out_cnt_next;
  logic [COUNT_BITS-1:0] rec_end, rec_end_mid, rec_end_next;
  logic [7:0]            lit_left, lit_left_mid, lit_left_next;
  logic [7:0]            run_len, run_mid, run_len_next;
  logic [31:0]           rec_cnt, rec_mid, rec_cnt_next;
  logic [1:0]            outcome, oc_mid, outcome_next;
  logic [SRC_BITS-1:0]   fail_pos, fpos_mid, fail_pos_next;
  logic                  tail_zero, tail_mid, tail_zero_next;
  logic [COUNT_BITS-1:0] lit_mark, mark_mid, lit_mark_next;
  logic                  stop_after_first;

  // Shared per-byte terms.
  logic                  accept, active, last;
  logic [7:0]            b;
  logic [SRC_BITS-1:0]   s;
  logic [31:0]           word_shift;
  logic [3:0]            fbc_inc;
  logic [COUNT_BITS-1:0] room;
  logic                  room_ne0, room_gt1, run_lt_room;
  logic [SUM_W-1:0]      size_sum;
  logic                  size_ovf, size_small, size_done;
  logic [7:0]            lit_dec;
  logic                  code_done, code_lt, complete, begin_size;

  // Final-result fields.
  logic                  pair_v;
  logic [7:0]            pair_rep;
  logic [1:0]            fin_kind;
  logic [COUNT_BITS-1:0] fin_dec;
  logic [31:0]           fin_rec;
  logic [SRC_BITS-1:0]   fin_pos;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !q_full;
  assign active = accept && (outcome == OC_NONE);
  assign last = in_ch.is_last;
  assign b = in_ch.src_byte;

  // Saturating source count after this byte.
  assign s = (src_cnt == SRC_MAX) ? src_cnt : src_cnt + 1'b1;
  assign word_shift = {word[23:0], b};
  assign fbc_inc = fbc + 4'd1;

  // Space left in the current record; the output count never passes its end.
  assign room = rec_end - out_cnt;
  assign room_ne0 = (room != '0);
  assign room_gt1 = (room > COUNT_BITS'(1));
  assign run_lt_room = (COUNT_BITS'(run_len) < room);

  // Record size checks.
  assign size_sum = SUM_W'(out_cnt) + SUM_W'(word_shift);
  assign size_ovf = |size_sum[SUM_W-1:COUNT_BITS];
  assign size_small = (word_shift < 32'(DESCRIPTOR_BYTES));
  assign size_done = (fbc_inc == FIELD_LAST);

  assign lit_dec = (lit_left != 8'd0) ? lit_left - 8'd1 : 8'd0;

  // End of a code: either more codes follow, a pad byte, or the record ends.
  always_comb begin
    code_done = 1'b0;
    case (phase)
      PH_DESC:    code_done = (fbc_inc == DESC_LAST);
      PH_RUNVAL:  code_done = 1'b1;
      PH_LITERAL: code_done = (lit_dec == 8'd0);
      default:    code_done = 1'b0;
    endcase
  end

  assign code_lt = (phase == PH_RUNVAL) ? run_lt_room : room_gt1;
  assign complete = active &&
                    ((phase == PH_PAD) || (code_done && !code_lt && !s[0]));
  assign begin_size = (active && (phase == PH_HEADER) && (fbc_inc >= FIELD_LAST) &&
                       (word_shift != 32'd0)) ||
                      (complete && !stop_after_first);

  // Next phase.
  always_comb begin
    ph_mid = phase;
    if (active) begin
      case (phase)
        PH_HEADER: begin
          if (begin_size) ph_mid = PH_SIZE;
        end
        PH_SIZE: begin
          if (size_done && (word_shift != 32'd0) && !size_small && !size_ovf) begin
            ph_mid = PH_DESC;
          end
        end
        PH_CONTROL: begin
          ph_mid = b[RUN_FLAG_BIT] ? PH_RUNVAL : PH_LITERAL;
        end
        PH_DESC, PH_RUNVAL, PH_LITERAL: begin
          if (code_done) begin
            if (code_lt) ph_mid = PH_CONTROL;
            else if (s[0]) ph_mid = PH_PAD;
            else if (begin_size) ph_mid = PH_SIZE;
          end
        end
        default: begin
          if (begin_size) ph_mid = PH_SIZE;
        end
      endcase
    end
    phase_next = (accept && last) ? PH_HEADER : ph_mid;
  end

  // Datapath updates, the outcome on the last byte, and the queue item.
  always_comb begin
    fbc_mid      = fbc;
    word_mid     = word;
    tail_mid     = tail_zero;
    out_mid      = out_cnt;
    rec_end_mid  = rec_end;
    lit_left_mid = lit_left;
    run_mid      = run_len;
    rec_mid      = rec_cnt;
    oc_mid       = outcome;
    fpos_mid     = fail_pos;
    mark_mid     = lit_mark;
    pair_v       = 1'b0;
    pair_rep     = 8'd1;

    if (active) begin
      case (phase)
        PH_HEADER: begin
          word_mid = word_shift;
          fbc_mid  = fbc_inc;
          if ((fbc_inc >= FIELD_LAST) && (word_shift == 32'd0)) begin
            oc_mid   = KIND_FAIL;
            fpos_mid = '0;
            out_mid  = '0;
          end
        end
        PH_SIZE: begin
          word_mid = word_shift;
          if (b != 8'd0) tail_mid = 1'b0;
          fbc_mid = fbc_inc;
          if (size_done) begin
            fbc_mid = 4'd0;
            if (word_shift == 32'd0) begin
              oc_mid = KIND_OK;
            end else if (size_small || size_ovf) begin
              oc_mid   = KIND_FAIL;
              fpos_mid = s;
            end else begin
              rec_end_mid = size_sum[COUNT_BITS-1:0];
            end
          end
        end
        PH_DESC: begin
          pair_v  = 1'b1;
          out_mid = out_cnt + 1'b1;
          fbc_mid = code_done ? 4'd0 : fbc_inc;
        end
        PH_CONTROL: begin
          if (b[RUN_FLAG_BIT]) begin
            run_mid = b - RUN_BIAS;
          end else begin
            run_mid      = b + 8'd1;
            lit_left_mid = b + 8'd1;
            mark_mid     = out_cnt;
          end
        end
        PH_RUNVAL: begin
          pair_v   = 1'b1;
          pair_rep = run_lt_room ? run_len : room[7:0];
          out_mid  = run_lt_room ? out_cnt + COUNT_BITS'(run_len) : rec_end;
        end
        PH_LITERAL: begin
          if (room_ne0) begin
            pair_v  = 1'b1;
            out_mid = out_cnt + 1'b1;
          end
          lit_left_mid = lit_dec;
        end
        default: begin
        end
      endcase

      // Record finished: count it and mark the offset after it.
      if (complete) begin
        rec_mid  = (rec_cnt == 32'hFFFF_FFFF) ? rec_cnt : rec_cnt + 32'd1;
        fpos_mid = s;
        if (stop_after_first) oc_mid = KIND_OK;
      end
      if (begin_size) begin
        fbc_mid  = 4'd0;
        word_mid = 32'd0;
        tail_mid = 1'b1;
      end
    end

    // Outcome of the stream when its last byte arrives.
    fin_kind = oc_mid;
    fin_dec  = out_mid;
    fin_rec  = rec_mid;
    fin_pos  = fpos_mid;
    if (s < SRC_BITS'(MIN_SOURCE)) begin
      fin_kind = KIND_FAIL;
      fin_dec  = '0;
      fin_rec  = 32'd0;
      fin_pos  = '0;
    end else if (oc_mid == OC_NONE) begin
      fin_kind = KIND_FAIL;
      case (ph_mid)
        PH_SIZE: begin
          if ((fbc_mid == 4'd0) || tail_mid) fin_kind = KIND_OK;
          else fin_pos = s - SRC_BITS'(fbc_mid);
        end
        PH_DESC: begin
          fin_pos = s - SRC_BITS'(fbc_mid);
          fin_dec = out_mid - COUNT_BITS'(fbc_mid);
        end
        PH_CONTROL, PH_RUNVAL: begin
          fin_pos = s;
        end
        PH_LITERAL: begin
          fin_pos = s - SRC_BITS'(run_mid - lit_left_mid);
          fin_dec = mark_mid;
        end
        PH_PAD: begin
          fin_pos = (s == SRC_MAX) ? s : s + 1'b1;
        end
        default: begin
          fin_dec = '0;
          fin_pos = '0;
        end
      endcase
    end

    q_push        = accept && (pair_v || last);
    q_data.pair_v = pair_v;
    q_data.value  = b;
    q_data.rep    = pair_rep;
    q_data.fin_v  = last;
    q_data.kind   = fin_kind;
    q_data.dec    = 32'(fin_dec);
    q_data.recs   = fin_rec;
    q_data.pos    = fin_pos;

    // After the outcome the stream state returns to its reset values.
    if (last) begin
      fbc_next       = 4'd0;
      word_next      = 32'd0;
      src_cnt_next   = '0;
      out_cnt_next   = '0;
      rec_end_next   = '0;
      lit_left_next  = 8'd0;
      run_len_next   = 8'd0;
      rec_cnt_next   = 32'd0;
      outcome_next   = OC_NONE;
      fail_pos_next  = '0;
      tail_zero_next = 1'b1;
      lit_mark_next  = '0;
    end else begin
      fbc_next       = fbc_mid;
      word_next      = word_mid;
      src_cnt_next   = s;
      out_cnt_next   = out_mid;
      rec_end_next   = rec_end_mid;
      lit_left_next  = lit_left_mid;
      run_len_next   = run_mid;
      rec_cnt_next   = rec_mid;
      outcome_next   = oc_mid;
      fail_pos_next  = fpos_mid;
      tail_zero_next = tail_mid;
      lit_mark_next  = mark_mid;
    end
  end

  // State registers, updated once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      fbc       <= 4'd0;
      word      <= 32'd0;
      src_cnt   <= '0;
      out_cnt   <= '0;
      rec_end   <= '0;
      lit_left  <= 8'd0;
      run_len   <= 8'd0;
      rec_cnt   <= 32'd0;
      outcome   <= OC_NONE;
      fail_pos  <= '0;
      tail_zero <= 1'b1;
      lit_mark  <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      fbc       <= fbc_next;
      word      <= word_next;
      src_cnt   <= src_cnt_next;
      out_cnt   <= out_cnt_next;
      rec_end   <= rec_end_next;
      lit_left  <= lit_left_next;
      run_len   <= run_len_next;
      rec_cnt   <= rec_cnt_next;
      outcome   <= outcome_next;
      fail_pos  <= fail_pos_next;
      tail_zero <= tail_zero_next;
      lit_mark  <= lit_mark_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_after_first <= 1'b0;
    end else if (cfg_we) begin
      stop_after_first <= cfg_wdata;
    end
  end

endmodule

`default_nettype wire

### rtl/core/srd_queue.sv
// ----------------------------------------------------------------------------
// Segmented RLE record decoder queue
// Short FIFO of result items between the front end and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_queue import srd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_data,
  input  wire logic   pop,
  output logic        full,
  output logic        q_valid,
  output entry_t      q_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = slots[rd_ptr];
  assign do_pop  = pop && q_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !do_pop) count <= count + 1'b1;
      else if (!push && do_pop) count <= count - 1'b1;
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

### rtl/core/srd_back.sv
// ----------------------------------------------------------------------------
// Segmented RLE record decoder output stage
// Takes queue items and presents the decoded pair, then the outcome, on the
// result channel from an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_back import srd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_valid,
  input  wire entry_t q_data,
  output logic        pop,
  srd_out_if.source   out_ch
);

  entry_t cur;
  logic   cur_valid;
  logic   sent;
  logic   pair_step, out_fire, done, load;

  // The pair of an item goes out first, its outcome after it.
  assign pair_step = cur.pair_v && !sent;
  assign out_fire  = out_ch.valid && out_ch.ready;
  assign done      = out_fire && !(pair_step && cur.fin_v);
  assign load      = !cur_valid || done;
  assign pop       = load && q_valid;

  assign out_ch.valid           = cur_valid;
  assign out_ch.kind            = pair_step ? KIND_DATA : cur.kind;
  assign out_ch.value           = pair_step ? cur.value : 8'd0;
  assign out_ch.repeat_res      = pair_step ? cur.rep : 8'd0;
  assign out_ch.decoded_total   = pair_step ? 32'd0 : cur.dec;
  assign out_ch.records_done    = pair_step ? 32'd0 : cur.recs;
  assign out_ch.source_position = pair_step ? '0 : cur.pos;
  assign out_ch.is_final        = !pair_step;

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      sent      <= 1'b0;
    end else if (load) begin
      cur_valid <= q_valid;
      sent      <= 1'b0;
    end else if (out_fire) begin
      sent <= 1'b1;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (pop) cur <= q_data;
  end

endmodule

`default_nettype wire
